// File: rtl/lpfd_pkg.sv
// shared constants and types for the length-prefixed frame deframer
package lpfd_pkg;

	localparam logic [31:0] FRAME_MAGIC = 32'h4654_4631;
	localparam int HDR_BYTES = 4 + 1 + 1 + 4 + 8;
	localparam logic [12:0] NAME_CAP = 13'd4096;
	localparam logic [7:0] HDR_VERSION = 8'd1;
	localparam logic [7:0] HDR_TYPE = 8'd1;

	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_NAME = 2'd1;
	localparam logic [1:0] KIND_PAYLOAD = 2'd2;
	localparam logic [1:0] KIND_DISCARD = 2'd3;

	localparam logic [2:0] ERR_NONE = 3'd0;
	localparam logic [2:0] ERR_MAGIC = 3'd1;
	localparam logic [2:0] ERR_VERSION = 3'd2;
	localparam logic [2:0] ERR_TYPE = 3'd3;
	localparam logic [2:0] ERR_NAME_LEN = 3'd4;
	localparam logic [2:0] ERR_SIZE = 3'd5;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [62:0] offset;
		logic [12:0] name_len;
		logic [62:0] payload_size;
		logic done;
		logic err_flag;
		logic [2:0] err_code;
	} lpfd_res_t;

endpackage

// File: rtl/lpfd_hdr_check.sv
// header validation, first failing check wins
module lpfd_hdr_check (
	input logic [31:0] magic,
	input logic [7:0] version,
	input logic [7:0] frame_type,
	input logic [31:0] name_len,
	input logic size_msb,
	input logic [12:0] max_name_len,
	output logic [2:0] code
);
	import lpfd_pkg::*;

	logic [12:0] limit;

	assign limit = (max_name_len > NAME_CAP) ? NAME_CAP : max_name_len;

	always_comb begin
		if (magic != FRAME_MAGIC) begin
			code = ERR_MAGIC;
		end else if (version != HDR_VERSION) begin
			code = ERR_VERSION;
		end else if (frame_type != HDR_TYPE) begin
			code = ERR_TYPE;
		end else if (name_len == 32'd0 || name_len > {19'd0, limit}) begin
			code = ERR_NAME_LEN;
		end else if (size_msb) begin
			code = ERR_SIZE;
		end else begin
			code = ERR_NONE;
		end
	end

endmodule

// File: rtl/lpfd_core.sv
// deframer state: header capture, section counting and word tagging
module lpfd_core (
	input logic clk,
	input logic arst_n,
	input logic advance,
	input logic [7:0] data_in,
	input logic [12:0] max_name_len,
	output lpfd_pkg::lpfd_res_t res
);
	import lpfd_pkg::*;

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_NAME = 2'd1;
	localparam logic [1:0] PH_PAYLOAD = 2'd2;
	localparam logic [1:0] PH_ERROR = 2'd3;
	localparam logic [4:0] HDR_LAST = 5'(HDR_BYTES - 1);

	logic [1:0] phase_q, phase_d;
	logic [4:0] hdr_cnt_q, hdr_cnt_d;
	logic [62:0] cnt_q, cnt_d;
	logic [31:0] magic_q;
	logic [7:0] version_q;
	logic [7:0] type_q;
	logic [31:0] name_len_q;
	logic [63:0] size_q;
	logic [63:0] size_next;
	logic [63:0] cnt_inc;
	logic name_last;
	logic payload_last;
	logic hdr_last;
	logic [2:0] chk_code;

	assign size_next = {size_q[55:0], data_in};
	assign hdr_last = (hdr_cnt_q == HDR_LAST);
	assign cnt_inc = {1'b0, cnt_q} + 64'd1;
	assign name_last = (cnt_inc >= {32'd0, name_len_q});
	assign payload_last = (cnt_inc >= size_q);

	// name length is complete by the last header byte, only size still shifts
	lpfd_hdr_check u_check (
		.magic(magic_q),
		.version(version_q),
		.frame_type(type_q),
		.name_len(name_len_q),
		.size_msb(size_next[63]),
		.max_name_len(max_name_len),
		.code(chk_code)
	);

	always_comb begin
		res = '0;
		res.data = data_in;
		res.kind = KIND_DISCARD;
		phase_d = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		cnt_d = cnt_q;
		unique case (phase_q)
			PH_HEADER: begin
				res.kind = KIND_HEADER;
				res.offset = {58'd0, hdr_cnt_q};
				if (hdr_last) begin
					hdr_cnt_d = '0;
					if (chk_code != ERR_NONE) begin
						res.err_flag = 1'b1;
						res.err_code = chk_code;
						phase_d = PH_ERROR;
					end else begin
						res.name_len = name_len_q[12:0];
						res.payload_size = size_next[62:0];
						cnt_d = '0;
						phase_d = PH_NAME;
					end
				end else begin
					hdr_cnt_d = hdr_cnt_q + 5'd1;
				end
			end
			PH_NAME: begin
				res.kind = KIND_NAME;
				res.offset = cnt_q;
				res.name_len = name_len_q[12:0];
				res.payload_size = size_q[62:0];
				if (name_last) begin
					cnt_d = '0;
					if (size_q == 64'd0) begin
						res.done = 1'b1;
						phase_d = PH_HEADER;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end else begin
					cnt_d = cnt_inc[62:0];
				end
			end
			PH_PAYLOAD: begin
				res.kind = KIND_PAYLOAD;
				res.offset = cnt_q;
				res.name_len = name_len_q[12:0];
				res.payload_size = size_q[62:0];
				if (payload_last) begin
					cnt_d = '0;
					res.done = 1'b1;
					phase_d = PH_HEADER;
				end else begin
					cnt_d = cnt_inc[62:0];
				end
			end
			PH_ERROR: begin
				res.kind = KIND_DISCARD;
			end
			default: begin
				res.kind = KIND_DISCARD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_cnt_q <= '0;
			cnt_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			cnt_q <= cnt_d;
		end
	end

	// header fields shift in big-endian; every field is rewritten each frame
	always_ff @(posedge clk) begin
		if (advance && phase_q == PH_HEADER) begin
			if (hdr_cnt_q < 5'd4) begin
				magic_q <= {magic_q[23:0], data_in};
			end else if (hdr_cnt_q == 5'd4) begin
				version_q <= data_in;
			end else if (hdr_cnt_q == 5'd5) begin
				type_q <= data_in;
			end else if (hdr_cnt_q < 5'd10) begin
				name_len_q <= {name_len_q[23:0], data_in};
			end else begin
				size_q <= size_next;
			end
		end
	end

	a_error_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("error phase left without reset");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.done |=> phase_q == PH_HEADER && hdr_cnt_q == 5'd0)
		else $error("completed frame did not restart header");

	a_err_enters: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.err_flag |=> phase_q == PH_ERROR)
		else $error("header error did not enter discard");

	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= HDR_LAST)
		else $error("header count out of range");

endmodule

// File: rtl/length_prefixed_frame_deframer_top.sv
// Length-prefixed frame deframer: takes one stream byte per word and tags
// each byte as header, name, payload or discarded, with its section offset
// and the decoded lengths. One word is accepted every clock cycle with no
// bubbles while m_tready holds the output open; the input register loads at
// acceptance, and the result register loads from it once the output can
// take a word. The per-byte cost is one pass through the header check
// and the 64-bit section counter increment and compare. After a
// header error every later word is discarded until reset. The name length
// limit may be written only while no words are in flight.
module length_prefixed_frame_deframer_top (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata,        // in_byte
	output logic m_tvalid,
	input logic m_tready,
	// out_byte[7:0], section_offset[70:8], name_length[83:71],
	// payload_size[146:84], error_flag[147], error_code[150:148], zero[151]
	output logic [151:0] m_tdata,
	output logic [1:0] m_tuser,       // byte_kind
	output logic m_tlast,             // frame_done
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [12:0] cfg_data       // max_name_length
);
	import lpfd_pkg::*;

	logic valid_s1;
	logic [7:0] data_s1;
	logic advance;
	logic out_valid_q;
	lpfd_res_t res;
	lpfd_res_t res_q;
	logic [12:0] max_name_len_q;

	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= NAME_CAP;
		end else if (cfg_valid) begin
			max_name_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			data_s1 <= s_tdata;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	lpfd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.data_in(data_s1),
		.max_name_len(max_name_len_q),
		.res(res)
	);

	assign m_tvalid = out_valid_q;
	assign m_tuser = res_q.kind;
	assign m_tlast = res_q.done;
	assign m_tdata = {1'b0, res_q.err_code, res_q.err_flag, res_q.payload_size,
		res_q.name_len, res_q.offset, res_q.data};

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(data_s1))
		else $error("stalled input word lost");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("processed word not presented");

endmodule
